### rtl/lfk_pkg.sv
package lfk_pkg;

  // Fixed-point formats.
  localparam int ANGLE_W      = 16;
  localparam int SUM_W        = 17;
  localparam int Q30_W        = 36;
  localparam int TRIG_W       = 16;
  localparam int POS_W        = 18;
  localparam int REG_W        = 16;
  localparam int LEN_W        = 15;
  localparam int CFG_IDX_W    = 3;

  // The angle reduction and the Q30 width are sized for this fraction width.
  localparam int ANGLE_FRAC_BITS       = 13;
  localparam int SINCOS_ITERATIONS_DEF = 16;
  localparam int MAX_ITER              = 24;

  localparam logic signed [Q30_W-1:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [Q30_W-1:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [Q30_W-1:0] Q30_TWO_PI  = 36'sd6746518852;
  localparam logic signed [Q30_W-1:0] Q30_GAIN    = 36'sd652032875;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BS_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BS_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BS_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SL_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UL_L = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LL_L = 3'd5;

  typedef logic signed [TRIG_W-1:0] trig_t;

  typedef struct packed {
    logic signed [REG_W-1:0] bs_x;
    logic signed [REG_W-1:0] bs_y;
    logic signed [REG_W-1:0] bs_z;
    logic signed [REG_W-1:0] sl_y;
    logic [LEN_W-1:0]        ul_len;
    logic [LEN_W-1:0]        ll_len;
  } geom_t;

  // Arctangent table in Q30 radians.
  function automatic logic signed [Q30_W-1:0] atan_q30(input logic [4:0] i);
    logic signed [Q30_W-1:0] r;
    case (i)
      5'd0:  r = 36'sd843314857;
      5'd1:  r = 36'sd497837829;
      5'd2:  r = 36'sd263043837;
      5'd3:  r = 36'sd133525159;
      5'd4:  r = 36'sd67021687;
      5'd5:  r = 36'sd33543516;
      5'd6:  r = 36'sd16775851;
      5'd7:  r = 36'sd8388437;
      5'd8:  r = 36'sd4194283;
      5'd9:  r = 36'sd2097149;
      default: r = 36'sd1 <<< (5'd30 - i);
    endcase
    return r;
  endfunction

endpackage

### rtl/lfk_stream_if.sv
interface lfk_stream_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/lfk_cordic.sv
// Pipelined sine/cosine: one angle reduction stage, one stage per rotation,
// one rounding stage. Advances when en is high.
module lfk_cordic #(
  parameter int SINCOS_ITERATIONS = lfk_pkg::SINCOS_ITERATIONS_DEF
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [lfk_pkg::SUM_W-1:0] angle,
  output lfk_pkg::trig_t                 sin_o,
  output lfk_pkg::trig_t                 cos_o
);
  localparam int NIT = (SINCOS_ITERATIONS < lfk_pkg::MAX_ITER) ?
                       SINCOS_ITERATIONS : lfk_pkg::MAX_ITER;
  localparam int W = lfk_pkg::Q30_W;
  localparam logic signed [W-1:0] Q30_TWO_PI_C = lfk_pkg::Q30_TWO_PI;

  logic signed [W-1:0] x [NIT+1];
  logic signed [W-1:0] y [NIT+1];
  logic signed [W-1:0] z [NIT+1];
  logic                neg [NIT+1];

  // Angle reduction: the input magnitude stays under two turns, so two
  // compare-and-subtract steps on a Q30 value replace the modulo.
  logic signed [W-1:0] z_in, z_m, z_r;
  logic                neg_in;
  always_comb begin
    z_in = W'(angle) <<< (30 - lfk_pkg::ANGLE_FRAC_BITS);
    // C remainder keeps the sign of the dividend.
    z_m = z_in;
    if (z_m >= Q30_TWO_PI_C)       z_m = z_m - Q30_TWO_PI_C;
    else if (z_m <= -Q30_TWO_PI_C) z_m = z_m + Q30_TWO_PI_C;
    if (z_m > lfk_pkg::Q30_PI)       z_m = z_m - lfk_pkg::Q30_TWO_PI;
    else if (z_m < -lfk_pkg::Q30_PI) z_m = z_m + lfk_pkg::Q30_TWO_PI;
    neg_in = 1'b0;
    z_r = z_m;
    if (z_m > lfk_pkg::Q30_HALF_PI) begin
      z_r = z_m - lfk_pkg::Q30_PI;
      neg_in = 1'b1;
    end else if (z_m < -lfk_pkg::Q30_HALF_PI) begin
      z_r = z_m + lfk_pkg::Q30_PI;
      neg_in = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]   <= lfk_pkg::Q30_GAIN;
      y[0]   <= '0;
      z[0]   <= z_r;
      neg[0] <= neg_in;
    end
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < NIT; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (en) begin
        neg[i+1] <= neg[i];
        if (!z[i][W-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - lfk_pkg::atan_q30(5'(i));
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + lfk_pkg::atan_q30(5'(i));
        end
      end
    end
  end

  // Sign fold, round half up to Q1.14 and clamp.
  function automatic lfk_pkg::trig_t rnd(input logic signed [W-1:0] v);
    logic signed [W-1:0] r;
    r = (v + W'(32768)) >>> 16;
    if (r > W'(16384)) return 16'sd16384;
    if (r < -W'(16384)) return -16'sd16384;
    return r[15:0];
  endfunction

  logic signed [W-1:0] xf, yf;
  assign xf = neg[NIT] ? -x[NIT] : x[NIT];
  assign yf = neg[NIT] ? -y[NIT] : y[NIT];

  always_ff @(posedge clk) begin
    if (en) begin
      sin_o <= rnd(yf);
      cos_o <= rnd(xf);
    end
  end
endmodule

### rtl/lfk_assemble.sv
// Position and rotation assembly: products, then sums, then round/saturate.
module lfk_assemble (
  input  logic                clk,
  input  logic                en,
  input  lfk_pkg::geom_t      geom,
  input  lfk_pkg::trig_t      ss,
  input  lfk_pkg::trig_t      cs,
  input  lfk_pkg::trig_t      sl,
  input  lfk_pkg::trig_t      cl,
  input  lfk_pkg::trig_t      sf,
  input  lfk_pkg::trig_t      cf,
  output logic [lfk_pkg::POS_W*3+16*8-1:0] res
);
  // Stage 1: first products.
  logic signed [31:0] p_fs, p_ls, p_fc, p_lc, p_ycs, p_yss;
  logic signed [31:0] r2, r3, r5, r6;
  lfk_pkg::trig_t     ss1, cs1, sf1, cf1;
  logic signed [15:0] bx1, by1, bz1;
  always_ff @(posedge clk) begin
    if (en) begin
      p_fs  <= $signed({1'b0, geom.ll_len}) * sf;
      p_ls  <= $signed({1'b0, geom.ul_len}) * sl;
      p_fc  <= $signed({1'b0, geom.ll_len}) * cf;
      p_lc  <= $signed({1'b0, geom.ul_len}) * cl;
      p_ycs <= geom.sl_y * cs;
      p_yss <= geom.sl_y * ss;
      r2 <= cf * ss;
      r3 <= -(sf * ss);
      r5 <= -(cf * cs);
      r6 <= sf * cs;
      ss1 <= ss; cs1 <= cs; sf1 <= sf; cf1 <= cf;
      bx1 <= geom.bs_x; by1 <= geom.bs_y; bz1 <= geom.bs_z;
    end
  end

  // Stage 2: x sum, reach, rotation rounding.
  logic signed [33:0] sx2, reach2;
  logic signed [31:0] ycs2, yss2;
  lfk_pkg::trig_t     ss2, cs2, sf2, cf2, q2, q3, q5, q6;
  logic signed [15:0] by2, bz2;
  always_ff @(posedge clk) begin
    if (en) begin
      sx2    <= 34'(bx1) * 34'sd16384 + 34'(p_fs) + 34'(p_ls);
      reach2 <= 34'(p_fc) + 34'(p_lc);
      ycs2 <= p_ycs; yss2 <= p_yss;
      q2 <= 16'((r2 + 32'sd8192) >>> 14);
      q3 <= 16'((r3 + 32'sd8192) >>> 14);
      q5 <= 16'((r5 + 32'sd8192) >>> 14);
      q6 <= 16'((r6 + 32'sd8192) >>> 14);
      ss2 <= ss1; cs2 <= cs1; sf2 <= sf1; cf2 <= cf1;
      by2 <= by1; bz2 <= bz1;
    end
  end

  // Stage 3: reach products.
  logic signed [49:0] rs3, rc3;
  logic signed [47:0] ycs3, yss3;
  logic signed [33:0] sx3;
  lfk_pkg::trig_t     ss3, cs3, sf3, cf3, q2_3, q3_3, q5_3, q6_3;
  logic signed [15:0] by3, bz3;
  always_ff @(posedge clk) begin
    if (en) begin
      rs3  <= reach2 * ss2;
      rc3  <= reach2 * cs2;
      ycs3 <= 48'(ycs2) * 48'sd16384;
      yss3 <= 48'(yss2) * 48'sd16384;
      sx3 <= sx2;
      ss3 <= ss2; cs3 <= cs2; sf3 <= sf2; cf3 <= cf2;
      q2_3 <= q2; q3_3 <= q3; q5_3 <= q5; q6_3 <= q6;
      by3 <= by2; bz3 <= bz2;
    end
  end

  // Stage 4: y/z sums.
  logic signed [51:0] sy4, sz4;
  logic signed [33:0] sx4;
  lfk_pkg::trig_t     ss4, cs4, sf4, cf4, q2_4, q3_4, q5_4, q6_4;
  always_ff @(posedge clk) begin
    if (en) begin
      sy4 <= (52'(by3) <<< 28) + 52'(ycs3) + 52'(rs3);
      sz4 <= (52'(bz3) <<< 28) + 52'(yss3) - 52'(rc3);
      sx4 <= sx3;
      ss4 <= ss3; cs4 <= cs3; sf4 <= sf3; cf4 <= cf3;
      q2_4 <= q2_3; q3_4 <= q3_3; q5_4 <= q5_3; q6_4 <= q6_3;
    end
  end

  function automatic logic [17:0] sat(input logic signed [51:0] v, input int f);
    logic signed [51:0] r;
    r = (v + (52'sd1 <<< (f - 1))) >>> f;
    if (r > 52'sd131071) return 18'h1FFFF;
    if (r < -52'sd131072) return 18'h20000;
    return r[17:0];
  endfunction

  // Stage 5: round, saturate and pack.
  always_ff @(posedge clk) begin
    if (en) begin
      res <= {sat(52'(sx4), 14), sat(sy4, 28), sat(sz4, 28),
              sf4, cf4, q2_4, q3_4, -cs4, q5_4, q6_4, -ss4};
    end
  end
endmodule

### rtl/leg_forward_kinematics_core.sv
// Throughput: one item per cycle; the pipeline stalls as a whole when the
// output is held and the two-entry output queue cannot take the result in flight.
// Input ready follows output ready and the queue fill combinationally.
// Reset: rst (synchronous) clears all valid bits and loads the geometry
// registers with their default values.
module leg_forward_kinematics_core #(
  parameter int SINCOS_ITERATIONS = lfk_pkg::SINCOS_ITERATIONS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  lfk_stream_if.sink                     in_ch,
  lfk_stream_if.source                   out_ch,
  input  logic                           cfg_we,
  input  logic [lfk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lfk_pkg::REG_W-1:0]      cfg_data
);
  localparam int NIT = (SINCOS_ITERATIONS < lfk_pkg::MAX_ITER) ?
                       SINCOS_ITERATIONS : lfk_pkg::MAX_ITER;
  localparam int LAT = NIT + 7;
  localparam int RW  = lfk_pkg::POS_W * 3 + 16 * 8;

  // Geometry registers.
  lfk_pkg::geom_t geom;
  always_ff @(posedge clk) begin
    if (rst) begin
      geom.bs_x   <= 16'sd3349;
      geom.bs_y   <= -16'sd1638;
      geom.bs_z   <= '0;
      geom.sl_y   <= -16'sd1163;
      geom.ul_len <= 15'd3277;
      geom.ll_len <= 15'd3277;
    end else if (cfg_we) begin
      case (cfg_index)
        lfk_pkg::REG_BS_X: geom.bs_x   <= cfg_data;
        lfk_pkg::REG_BS_Y: geom.bs_y   <= cfg_data;
        lfk_pkg::REG_BS_Z: geom.bs_z   <= cfg_data;
        lfk_pkg::REG_SL_Y: geom.sl_y   <= cfg_data;
        lfk_pkg::REG_UL_L: geom.ul_len <= cfg_data[14:0];
        lfk_pkg::REG_LL_L: geom.ll_len <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: stall when the output is held and the queue is full, or holds one entry while a result arrives.
  logic [1:0]     cnt;
  logic           en;
  logic [LAT-1:0] vld;
  assign en = (cnt == 2'd0) || (cnt == 2'd1 && !vld[LAT-1]) || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], in_ch.valid};
  end

  logic signed [15:0] a_s, a_l, a_f;
  assign a_s = in_ch.data[47:32];
  assign a_l = in_ch.data[31:16];
  assign a_f = in_ch.data[15:0];

  lfk_pkg::trig_t ss, cs, sl, cl, sf, cf;
  lfk_cordic #(.SINCOS_ITERATIONS(SINCOS_ITERATIONS))
    u_cs (.clk, .en, .angle(17'(a_s)), .sin_o(ss), .cos_o(cs));
  lfk_cordic #(.SINCOS_ITERATIONS(SINCOS_ITERATIONS))
    u_cl (.clk, .en, .angle(17'(a_l)), .sin_o(sl), .cos_o(cl));
  lfk_cordic #(.SINCOS_ITERATIONS(SINCOS_ITERATIONS))
    u_cf (.clk, .en, .angle(17'(a_l) + 17'(a_f)), .sin_o(sf), .cos_o(cf));

  logic [RW-1:0] res;
  lfk_assemble u_asm (.clk, .en, .geom, .ss, .cs, .sl, .cl, .sf, .cf, .res);

  // Output queue of two entries; while the output is held, it takes a result only when empty.
  logic [RW-1:0] q [2];
  logic          push, pop;
  assign push = en && vld[LAT-1];
  assign pop  = out_ch.valid && out_ch.ready;
  assign out_ch.valid = (cnt != 2'd0);
  assign out_ch.data  = q[0];
  always_ff @(posedge clk) begin
    if (rst) cnt <= '0;
    else cnt <= cnt + 2'(push) - 2'(pop);
  end
  always_ff @(posedge clk) begin
    if (pop) begin
      q[0] <= q[1];
      if (push && cnt == 2'd1) q[0] <= res;
      if (push && cnt == 2'd2) q[1] <= res;
    end else if (push) begin
      if (cnt == 2'd0) q[0] <= res;
      else             q[1] <= res;
    end
  end

  // Checks.
  a_cnt_max: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("output queue overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && !pop) |-> !push) else $error("push into full queue");
  a_valid_cnt: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid == (cnt != 2'd0)) else $error("valid mismatch");
endmodule

### tb/tb.sv
module tb;

  localparam int IN_W = 3 * lfk_pkg::ANGLE_W;
  localparam int OUT_W = 3 * lfk_pkg::POS_W + 8 * lfk_pkg::TRIG_W;
  localparam int PIPE_LAT = lfk_pkg::SINCOS_ITERATIONS_DEF + 7;
  localparam int STALL_LIMIT = 4000;
  localparam int NUM_REGS = 6;

  typedef struct packed {
    logic signed [lfk_pkg::POS_W-1:0] px;
    logic signed [lfk_pkg::POS_W-1:0] py;
    logic signed [lfk_pkg::POS_W-1:0] pz;
    logic [7:0][lfk_pkg::TRIG_W-1:0] rot;
  } pose_t;

  typedef struct {
    int shoulder;
    int upper;
    int foot;
  } angles_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [lfk_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lfk_pkg::REG_W-1:0] cfg_data;

  lfk_stream_if #(.W(IN_W)) in_ch ();
  lfk_stream_if #(.W(OUT_W)) out_ch ();

  leg_forward_kinematics_core uut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Predictor copy of the geometry registers.
  longint geom[NUM_REGS];
  pose_t pose_q[$];
  int errors;
  int idle_cycles;
  bit calm;
  longint arctan[24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128
  };

  // Directed angle sets: zero, extremes, pi and half-pi folds, sum past 16 bits.
  angles_t corner_tbl[16] = '{
    '{0, 0, 0}, '{-32768, -32768, -32768}, '{32767, 32767, 32767},
    '{25736, 0, 0}, '{-25736, 0, 0}, '{25735, 25735, 0},
    '{12868, 12868, -12868}, '{12867, -12867, 12867},
    '{-12868, -12869, 0}, '{32767, 32767, -32768},
    '{0, 32767, 32767}, '{0, -32768, -32768}, '{8192, 4096, 2048},
    '{-1, 1, -1}, '{1, -1, 1}, '{21000, -30000, 30000}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // CORDIC sine and cosine, rounded to Q1.14.
  function automatic void sin_cos(input longint ang, output longint s, output longint c);
    longint z, x, y, dx, dy;
    bit flip;
    z = ang * (64'sd1 <<< (30 - lfk_pkg::ANGLE_FRAC_BITS));
    x = 652032875;
    y = 0;
    flip = 0;
    z = z % 64'sd6746518852;
    if (z > 64'sd3373259426) z -= 64'sd6746518852;
    if (z < -64'sd3373259426) z += 64'sd6746518852;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426;
      flip = 1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426;
      flip = 1;
    end
    for (int i = 0; i < lfk_pkg::SINCOS_ITERATIONS_DEF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan[i];
      end else begin
        x += dx; y -= dy; z += arctan[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = clip((y + 32768) >>> 16, -16384, 16384);
    c = clip((x + 32768) >>> 16, -16384, 16384);
  endfunction

  function automatic longint rnd_mul(longint a, longint b);
    return (a * b + 8192) >>> 14;
  endfunction

  function automatic logic [lfk_pkg::POS_W-1:0] sat_pos(longint acc, int frac);
    return lfk_pkg::POS_W'(clip((acc + (64'sd1 <<< (frac - 1))) >>> frac,
                                -131072, 131071));
  endfunction

  function automatic pose_t leg_pose(angles_t a);
    pose_t p;
    longint ss, cs, sl, cl, sf, cf, reach, bx, by, bz, sy, ul, ll;
    bx = geom[0]; by = geom[1]; bz = geom[2]; sy = geom[3];
    ul = geom[4]; ll = geom[5];
    sin_cos(a.shoulder, ss, cs);
    sin_cos(a.upper, sl, cl);
    sin_cos(longint'(a.upper) + a.foot, sf, cf);
    reach = ll * cf + ul * cl;
    p.px = sat_pos(bx * 16384 + ll * sf + ul * sl, 14);
    p.py = sat_pos(by * 268435456 + sy * cs * 16384 + reach * ss, 28);
    p.pz = sat_pos(bz * 268435456 + sy * ss * 16384 - reach * cs, 28);
    p.rot[7] = lfk_pkg::TRIG_W'(sf);
    p.rot[6] = lfk_pkg::TRIG_W'(cf);
    p.rot[5] = lfk_pkg::TRIG_W'(rnd_mul(cf, ss));
    p.rot[4] = lfk_pkg::TRIG_W'(rnd_mul(-sf, ss));
    p.rot[3] = lfk_pkg::TRIG_W'(-cs);
    p.rot[2] = lfk_pkg::TRIG_W'(rnd_mul(-cf, cs));
    p.rot[1] = lfk_pkg::TRIG_W'(rnd_mul(sf, cs));
    p.rot[0] = lfk_pkg::TRIG_W'(-ss);
    return p;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Result side: random stalls on ready, compare each transfer.
  int stall_left;
  always @(posedge clk) begin
    pose_t got, want;
    int wait_n;
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (pose_q.size() == 0) begin
          report("unexpected result", 0, 0);
        end else begin
          want = pose_q.pop_front();
          if (got.px !== want.px) report("palm_x", got.px, want.px);
          if (got.py !== want.py) report("palm_y", got.py, want.py);
          if (got.pz !== want.pz) report("palm_z", got.pz, want.pz);
          for (int k = 0; k < 8; k++)
            if (got.rot[7-k] !== want.rot[7-k])
              report($sformatf("rot entry %0d", k), $signed(got.rot[7-k]),
                     $signed(want.rot[7-k]));
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else if (out_ch.ready && out_ch.valid && !calm) begin
        wait_n = $urandom_range(0, 3);
        stall_left <= (wait_n > 0) ? wait_n - 1 : 0;
        out_ch.ready <= (wait_n == 0);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic send_angles(angles_t a);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= {a.shoulder[15:0], a.upper[15:0], a.foot[15:0]};
    do @(posedge clk); while (!in_ch.ready);
    pose_q.insert(pose_q.size(), leg_pose(a));
  endtask

  function automatic int rand_angle();
    case ($urandom_range(0, 3))
      0: return $urandom_range(1, 5) * 12868 - 38604 + $urandom_range(0, 4) - 2;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  // Drain the pipeline before the registers are written.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 8) @(posedge clk);
  endtask

  // Write one register; the caller drops the write enable after the last one.
  task automatic write_reg(int idx, logic [lfk_pkg::REG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= lfk_pkg::CFG_IDX_W'(idx);
    cfg_data <= val;
    @(posedge clk);
    if (idx < NUM_REGS)
      geom[idx] = (idx >= lfk_pkg::REG_UL_L) ? longint'(val[lfk_pkg::LEN_W-1:0])
                                             : longint'($signed(val));
  endtask

  initial begin
    angles_t a;
    logic [lfk_pkg::REG_W-1:0] val;
    errors = 0;
    calm = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    geom = '{3349, -1638, 0, -1163, 3277, 3277};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int phase = 0; phase < 6; phase++) begin
      if (phase > 0) begin
        wait_drained();
        for (int r = 0; r < NUM_REGS; r++) begin
          case (phase)
            1: val = (r >= lfk_pkg::REG_UL_L) ? 16'h0000 : 16'h8000;
            2: val = 16'h7FFF;
            3: val = 16'hFFFF;
            default: val = 16'($urandom);
          endcase
          write_reg(r, val);
        end
        // Writes past the last register must be ignored.
        write_reg(NUM_REGS + phase % 2, 16'($urandom));
        cfg_we <= 1'b0;
      end
      calm = (phase == 4);
      if (phase < 3)
        foreach (corner_tbl[i]) send_angles(corner_tbl[i]);
      for (int n = 0; n < 240; n++) begin
        if (phase == 5) calm = ($urandom_range(0, 9) == 0);
        a.shoulder = rand_angle();
        a.upper = rand_angle();
        a.foot = rand_angle();
        send_angles(a);
      end
    end

    in_ch.valid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 8) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/lfk_pkg.sv
rtl/lfk_stream_if.sv
rtl/lfk_cordic.sv
rtl/lfk_assemble.sv
rtl/leg_forward_kinematics_core.sv
tb/tb.sv
